// ----- sv/stpg_pkg.sv -----
// ----------------------------------------------------------------------------
// stpg_pkg: shared definitions for the scroll table pattern generator
// Operation codes, sequencer states, the adder request bundle, beat layout
// and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package stpg_pkg;

    // Default table depth; must be a power of two
    localparam int TABLE_ENTRIES_DEF = 256;

    // Beat layout
    localparam int TDATA_W  = 64;
    localparam int TUSER_W  = 3;
    localparam int MDATA_W  = 8;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 8;

    // Register reset values
    localparam logic [7:0] MASK_RESET = 8'd0;
    localparam logic [7:0] KEY_RESET  = 8'd96;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_INDEX_MASK = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_KEY_THRESH = 1'b1;

    // Item operations; codes 6 and 7 are ignored
    typedef enum logic [2:0] {
        OP_LOAD_X  = 3'd0,
        OP_LOAD_Y  = 3'd1,
        OP_XOR     = 3'd2,
        OP_SCROLL  = 3'd3,
        OP_PLASMA  = 3'd4,
        OP_KEYED   = 3'd5
    } op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XOR,
        ST_FETCH,
        ST_SHIFT,
        ST_SCR_Y,
        ST_SCR_T,
        ST_COLADDR,
        ST_LINE,
        ST_SUM,
        ST_DONE
    } state_t;

    // Operands for the shared adder: sum = (a ^ c) + b
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } alu_req_t;

endpackage

`default_nettype wire

// ----- sv/scroll_table_pattern_generator.sv -----
// ----------------------------------------------------------------------------
// scroll_table_pattern_generator: plasma-style pixel pattern generator
// Two scroll lookup tables, one shared adder and a step sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry the operation in s_tuser and column, row, tick, table
//   index and table value in s_tdata. Load beats write one X or Y table entry
//   and return nothing; pixel beats return one 8-bit palette index on m_.
//   Configuration writes (index mask, key threshold) go in on cfg_wr_en.
// Timing:
//   Loads and unused codes leave the sequencer idle, with s_tready staying high.
//   A pixel item occupies the block from its accept edge to the earliest next
//   accept edge, through the sequencer steps of its kind (plain xor, scrolled
//   xor, or plasma and keyed plasma); the result beat appears on the cycle the
//   block turns ready again. The steps follow from the single adder and the
//   registered table read port, which the steps of the sequencer use in turn.
// Reset:
//   aresetn (synchronous, low) clears the sequencer and the output beat and
//   restores index_mask to 0 and key_threshold to 96. Table contents are
//   undefined until written.
// Stalls:
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and holds in its last step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module scroll_table_pattern_generator #(
    parameter int TABLE_ENTRIES = stpg_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // [7:0] column, [16:8] row, [32:17] tick, [40:33] table_index,
    // [56:41] table_value, [63:57] zero
    input  wire logic [stpg_pkg::TDATA_W-1:0] s_tdata,
    // [2:0] operation
    input  wire logic [stpg_pkg::TUSER_W-1:0] s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [7:0] pixel_value
    output logic [stpg_pkg::MDATA_W-1:0]      m_tdata,
    input  wire logic                         cfg_wr_en,
    input  wire logic [stpg_pkg::CFG_A_W-1:0] cfg_addr,
    input  wire logic [stpg_pkg::CFG_D_W-1:0] cfg_wr_data
);
    import stpg_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic          x_we, y_we, x_re, y_re;
    logic [AW-1:0] waddr, x_raddr, y_raddr;
    logic [15:0]   wdata, x_rd, y_rd, alu_sum;
    alu_req_t      alu_req;

    // Sequencer
    stpg_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .x_we        (x_we),
        .y_we        (y_we),
        .waddr       (waddr),
        .wdata       (wdata),
        .x_re        (x_re),
        .y_re        (y_re),
        .x_raddr     (x_raddr),
        .y_raddr     (y_raddr),
        .x_rd        (x_rd),
        .y_rd        (y_rd),
        .alu_req     (alu_req),
        .alu_sum     (alu_sum)
    );

    // Shared adder
    stpg_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    // X scroll table
    stpg_table_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_x_table (
        .aclk  (aclk),
        .we    (x_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (x_re),
        .raddr (x_raddr),
        .rdata (x_rd)
    );

    // Y scroll table
    stpg_table_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_y_table (
        .aclk  (aclk),
        .we    (y_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (y_re),
        .raddr (y_raddr),
        .rdata (y_rd)
    );

endmodule

`default_nettype wire

// ----- sv/stpg_alu.sv -----
// ----------------------------------------------------------------------------
// stpg_alu: shared 16-bit xor/add unit
// Computes (a ^ c) + b, wrapping at 16 bits. Every sum of the pattern
// generator and each read address past the tick fetch use this one unit.
// ----------------------------------------------------------------------------
`default_nettype none

module stpg_alu (
    input  var stpg_pkg::alu_req_t req,
    output logic [15:0]            sum
);
    import stpg_pkg::*;

    // Fold the xor operand in, then add
    assign sum = (req.a ^ req.c) + req.b;

endmodule

`default_nettype wire

// ----- sv/stpg_table_mem.sv -----
// ----------------------------------------------------------------------------
// stpg_table_mem: one scroll lookup table
// Single write port, single read port with registered read data that holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module stpg_table_mem #(
    parameter int DEPTH = stpg_pkg::TABLE_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic [15:0]        rdata
);
    import stpg_pkg::*;

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    // Write entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read entry, hold data between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/stpg_seq.sv -----
// ----------------------------------------------------------------------------
// stpg_seq: sequencer and datapath registers
// Takes input beats, writes table entries, steps pixel items through the
// shared adder and the table reads, and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module stpg_seq #(
    parameter int TABLE_ENTRIES = stpg_pkg::TABLE_ENTRIES_DEF,
    parameter int AW            = $clog2(TABLE_ENTRIES)
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [stpg_pkg::TDATA_W-1:0]     s_tdata,
    input  wire logic [stpg_pkg::TUSER_W-1:0]     s_tuser,
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [stpg_pkg::MDATA_W-1:0]          m_tdata,
    // configuration
    input  wire logic                             cfg_wr_en,
    input  wire logic [stpg_pkg::CFG_A_W-1:0]     cfg_addr,
    input  wire logic [stpg_pkg::CFG_D_W-1:0]     cfg_wr_data,
    // tables
    output logic                                  x_we,
    output logic                                  y_we,
    output logic [AW-1:0]                         waddr,
    output logic [15:0]                           wdata,
    output logic                                  x_re,
    output logic                                  y_re,
    output logic [AW-1:0]                         x_raddr,
    output logic [AW-1:0]                         y_raddr,
    input  wire logic [15:0]                      x_rd,
    input  wire logic [15:0]                      y_rd,
    // shared adder
    output stpg_pkg::alu_req_t                    alu_req,
    input  wire logic [15:0]                      alu_sum
);
    import stpg_pkg::*;

    state_t       state_reg, state_next;
    logic [2:0]   op_reg;
    logic [7:0]   col_reg;
    logic [8:0]   row_reg;
    logic [15:0]  tick_reg;
    logic [15:0]  a_reg;
    logic [15:0]  b_reg;
    logic [7:0]   res_reg;
    logic [7:0]   mask_reg;
    logic [7:0]   key_reg;
    logic         m_valid_reg;
    logic [7:0]   m_data_reg;

    logic [2:0]   in_op;
    logic [7:0]   in_col;
    logic [8:0]   in_row;
    logic [15:0]  in_tick;
    logic [7:0]   in_tidx;
    logic [15:0]  in_tval;
    logic         accept;
    logic         pix_done;
    logic         keyed_drop;
    logic [AW-1:0] mask_aw;
    logic [15:0]  g_shift;

    // Unpack the input beat
    assign in_op   = s_tuser[2:0];
    assign in_col  = s_tdata[7:0];
    assign in_row  = s_tdata[16:8];
    assign in_tick = s_tdata[32:17];
    assign in_tidx = s_tdata[40:33];
    assign in_tval = s_tdata[56:41];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mask_aw  = AW'(mask_reg);
    assign g_shift  = (op_reg == OP_KEYED) ? x_rd : y_rd;

    // Mask a sum down to a table index
    function automatic logic [AW-1:0] tbl_ix(input logic [15:0] v, input logic [AW-1:0] m);
        return v[AW-1:0] & m;
    endfunction

    // Table writes happen on the accepted load beat
    assign x_we  = accept && (in_op == OP_LOAD_X);
    assign y_we  = accept && (in_op == OP_LOAD_Y);
    assign waddr = AW'(in_tidx);
    assign wdata = in_tval;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_op) inside
                        OP_XOR:                        state_next = ST_XOR;
                        OP_SCROLL, OP_PLASMA, OP_KEYED: state_next = ST_FETCH;
                        default:                       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_XOR:     state_next = ST_DONE;
            ST_FETCH:   state_next = ST_SHIFT;
            ST_SHIFT:   state_next = (op_reg == OP_SCROLL) ? ST_SCR_Y : ST_COLADDR;
            ST_SCR_Y:   state_next = ST_SCR_T;
            ST_SCR_T:   state_next = ST_DONE;
            ST_COLADDR: state_next = ST_LINE;
            ST_LINE:    state_next = ST_SUM;
            ST_SUM:     state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Adder operands and table reads per step
    always_comb begin
        alu_req  = '{a: 16'd0, b: 16'd0, c: 16'd0};
        x_re     = 1'b0;
        y_re     = 1'b0;
        x_raddr  = tbl_ix(tick_reg, mask_aw);
        y_raddr  = tbl_ix(tick_reg, mask_aw);
        unique case (state_reg)
            ST_XOR: begin
                alu_req = '{a: {8'd0, col_reg}, b: tick_reg, c: {7'd0, row_reg}};
            end
            ST_FETCH: begin
                x_re = 1'b1;
                y_re = 1'b1;
            end
            ST_SHIFT: begin
                if (op_reg == OP_SCROLL) begin
                    alu_req = '{a: {8'd0, col_reg}, b: x_rd, c: 16'd0};
                end else begin
                    alu_req = '{a: g_shift, b: {7'd0, row_reg}, c: 16'd0};
                    y_re    = 1'b1;
                    y_raddr = tbl_ix(alu_sum, mask_aw);
                end
            end
            ST_SCR_Y: begin
                alu_req = '{a: {7'd0, row_reg}, b: y_rd, c: 16'd0};
            end
            ST_SCR_T: begin
                alu_req = '{a: a_reg, b: tick_reg, c: b_reg};
            end
            ST_COLADDR: begin
                alu_req = '{a: tick_reg, b: {8'd0, col_reg}, c: 16'd0};
                x_re    = 1'b1;
                x_raddr = tbl_ix(alu_sum, mask_aw);
            end
            ST_LINE: begin
                alu_req = '{a: y_rd, b: {tick_reg[13:0], 2'b00}, c: 16'd0};
            end
            ST_SUM: begin
                alu_req = '{a: a_reg, b: x_rd, c: 16'd0};
            end
            default: begin
                alu_req = '{a: 16'd0, b: 16'd0, c: 16'd0};
            end
        endcase
    end

    // Keyed plasma zeroes values at or below the threshold
    assign keyed_drop = (op_reg == OP_KEYED) && (alu_sum[7:0] <= key_reg);
    assign pix_done   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            mask_reg    <= MASK_RESET;
            key_reg     <= KEY_RESET;
        end else begin
            state_reg <= state_next;
            if (pix_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_INDEX_MASK: mask_reg <= cfg_wr_data;
                    CFG_KEY_THRESH: key_reg  <= cfg_wr_data;
                    default:        ;
                endcase
            end
        end
    end

    // Capture item fields and step results
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= in_op;
            col_reg  <= in_col;
            row_reg  <= in_row;
            tick_reg <= in_tick;
        end
        case (state_reg) inside
            ST_XOR, ST_SCR_T: res_reg <= alu_sum[7:0];
            ST_SHIFT:         a_reg   <= alu_sum;
            ST_SCR_Y:         b_reg   <= alu_sum;
            ST_LINE:          a_reg   <= alu_sum;
            ST_SUM:           res_reg <= keyed_drop ? 8'd0 : alu_sum[7:0];
            default:          ;
        endcase
        if (pix_done) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ----- sv/stpg_checker.sv -----
// ----------------------------------------------------------------------------
// stpg_checker: port-level checks for the pattern generator
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module stpg_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic [stpg_pkg::TUSER_W-1:0] s_tuser,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [stpg_pkg::MDATA_W-1:0] m_tdata
);
    import stpg_pkg::*;

    logic pix_beat;
    logic load_beat;

    assign pix_beat  = s_tvalid && s_tready &&
                       (s_tuser == OP_XOR || s_tuser == OP_SCROLL ||
                        s_tuser == OP_PLASMA || s_tuser == OP_KEYED);
    assign load_beat = s_tvalid && s_tready &&
                       (s_tuser == OP_LOAD_X || s_tuser == OP_LOAD_Y);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A pixel item keeps the block busy for at least the next cycle
    a_pix_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_beat |=> !s_tready)
        else $error("input ready right after a pixel beat");

    // The block is ready again in the cycle after a table load
    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        load_beat |=> s_tready)
        else $error("input not ready after a load beat");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

endmodule

bind scroll_table_pattern_generator stpg_checker u_stpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
